FILE: src/text_console_scrollback_assert.svh
// Assertion macros shared by the console scrollback RTL.
`ifndef TEXT_CONSOLE_SCROLLBACK_ASSERT_SVH
`define TEXT_CONSOLE_SCROLLBACK_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Implication checked on every clock edge outside reset.
`define TCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Condition that must never hold outside reset.
`define TCS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define TCS_ASSERT(lbl, prop, msg)
`define TCS_NEVER(lbl, cond, msg)
`endif
`endif

FILE: src/scb_pkg.sv
// Shared types and constants of the console scrollback block.
package scb_pkg;

    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] NEWLINE_CODE = 8'h0a;
    localparam logic [7:0] RESET_COLOR  = 8'd7;
    localparam logic [6:0] RESET_STEP   = 7'd3;

    localparam logic [2:0] ACT_PUT   = 3'd0;
    localparam logic [2:0] ACT_WHEEL = 3'd1;
    localparam logic [2:0] ACT_UNDO  = 3'd2;
    localparam logic [2:0] ACT_CLEAR = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    localparam logic REG_TEXT_COLOR  = 1'b0;
    localparam logic REG_SCROLL_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SHIFT,
        ST_PUT,
        ST_UNDO,
        ST_CLEAR,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic shift_begin;
        logic row_clr;
        logic put;
        logic undo_step;
        logic wheel;
        logic clear_begin;
        logic sweep;
        logic read_issue;
        logic cell_load;
    } t_cmd;

    typedef struct packed {
        logic row_full;
        logic at_origin;
        logic undo_zero;
        logic sweep_last;
        logic row_clr_last;
    } t_stat;

endpackage

FILE: src/scb_ctrl.sv
// Sequencing state machine of the console scrollback block.
module scb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [2:0]     i_action,
    input  scb_pkg::t_stat i_stat,
    output scb_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_done
);

    scb_pkg::t_state r_state;
    scb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scb_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            scb_pkg::ST_INIT: begin
                if (i_stat.sweep_last) n_state = scb_pkg::ST_IDLE;
            end
            scb_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (i_action)
                        scb_pkg::ACT_PUT: begin
                            n_state = i_stat.row_full ? scb_pkg::ST_SHIFT : scb_pkg::ST_PUT;
                        end
                        scb_pkg::ACT_UNDO:  n_state = scb_pkg::ST_UNDO;
                        scb_pkg::ACT_CLEAR: n_state = scb_pkg::ST_CLEAR;
                        scb_pkg::ACT_READ:  n_state = scb_pkg::ST_READ;
                        default:            n_state = scb_pkg::ST_DONE;
                    endcase
                end
            end
            scb_pkg::ST_SHIFT: begin
                if (i_stat.row_clr_last) n_state = scb_pkg::ST_PUT;
            end
            scb_pkg::ST_PUT:  n_state = scb_pkg::ST_DONE;
            scb_pkg::ST_UNDO: begin
                if (i_stat.undo_zero || i_stat.at_origin) n_state = scb_pkg::ST_DONE;
            end
            scb_pkg::ST_CLEAR: begin
                if (i_stat.sweep_last) n_state = scb_pkg::ST_DONE;
            end
            scb_pkg::ST_READ: n_state = scb_pkg::ST_DONE;
            scb_pkg::ST_DONE: n_state = scb_pkg::ST_IDLE;
            default:          n_state = scb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != scb_pkg::ST_IDLE);
        o_done = 1'b0;
        case (r_state)
            scb_pkg::ST_INIT: o_cmd.sweep = 1'b1;
            scb_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    case (i_action)
                        scb_pkg::ACT_PUT:   o_cmd.shift_begin = i_stat.row_full;
                        scb_pkg::ACT_WHEEL: o_cmd.wheel = 1'b1;
                        scb_pkg::ACT_CLEAR: o_cmd.clear_begin = 1'b1;
                        scb_pkg::ACT_READ:  o_cmd.read_issue = 1'b1;
                        default:            o_cmd.load = 1'b1;
                    endcase
                end
            end
            scb_pkg::ST_SHIFT: o_cmd.row_clr = 1'b1;
            scb_pkg::ST_PUT:   o_cmd.put = 1'b1;
            scb_pkg::ST_UNDO:  o_cmd.undo_step = !(i_stat.undo_zero || i_stat.at_origin);
            scb_pkg::ST_CLEAR: o_cmd.sweep = 1'b1;
            scb_pkg::ST_READ:  o_cmd.cell_load = 1'b1;
            scb_pkg::ST_DONE:  o_done = 1'b1;
            default:           o_done = 1'b0;
        endcase
    end

endmodule

FILE: src/scb_dp.sv
// Datapath of the console scrollback block: cursor, window and cell store.
module scb_dp #(
    parameter int COLUMNS      = 80,
    parameter int VISIBLE_ROWS = 25,
    parameter int HISTORY_ROWS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scb_pkg::t_cmd      i_cmd,
    output scb_pkg::t_stat     o_stat,
    input  logic [7:0]         i_text_color,
    input  logic [6:0]         i_scroll_step,
    input  logic [7:0]         i_char_code,
    input  logic signed [31:0] i_wheel_value,
    input  logic [7:0]         i_undo_count,
    input  logic [4:0]         i_view_row,
    input  logic [6:0]         i_view_column,
    output logic [15:0]        o_cell_entry,
    output logic [6:0]         o_cursor_column,
    output logic [7:0]         o_cursor_view_row,
    output logic               o_cursor_visible,
    output logic [6:0]         o_window_position
);

    localparam int RW    = $clog2(HISTORY_ROWS + 1);
    localparam int PW    = $clog2(HISTORY_ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = PW + CW;
    localparam int DEPTH = HISTORY_ROWS * (2 ** CW);
    localparam int XW    = ((RW > 7) ? RW : 7) + 2;

    localparam logic [RW-1:0] ROW_FULL  = RW'(HISTORY_ROWS);
    localparam logic [RW-1:0] ROW_LAST  = RW'(HISTORY_ROWS - 1);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [XW-1:0] VIS       = XW'(VISIBLE_ROWS);
    localparam logic [XW-1:0] HIST      = XW'(HISTORY_ROWS);
    localparam logic [AW-1:0] CNT_LAST  = AW'(DEPTH - 1);

    localparam logic [1:0] RD_ZERO  = 2'd0;
    localparam logic [1:0] RD_BLANK = 2'd1;
    localparam logic [1:0] RD_MEM   = 2'd2;

    logic [15:0]        r_mem [DEPTH];
    logic [RW-1:0]      r_row, n_row;
    logic [CW-1:0]      r_col, n_col;
    logic [RW-1:0]      r_view, n_view;
    logic signed [31:0] r_prev, n_prev;
    logic [PW-1:0]      r_base, n_base;
    logic [7:0]         r_fill_attr, n_fill_attr;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic [PW-1:0]      r_clr_row;
    logic [7:0]         r_char;
    logic [7:0]         r_undo;
    logic [15:0]        r_cell;
    logic [15:0]        r_rd_data;
    logic [1:0]         r_rd_mode;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [15:0]        w_wdata;
    logic [AW-1:0]      w_raddr;
    logic [1:0]         w_rd_mode;
    logic [XW-1:0]      w_rowx, w_viewx, w_stepx, w_room, w_rdrow;
    logic [RW-1:0]      w_ub_row;
    logic [CW-1:0]      w_ub_col;
    logic [8:0]         w_vc_ext;
    logic [31:0]        w_rel, w_col32, w_view32;

    function automatic logic [PW-1:0] f_phys(input logic [PW-1:0] l, input logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, l} + {1'b0, b};
        if (s >= (PW + 1)'(HISTORY_ROWS)) s = s - (PW + 1)'(HISTORY_ROWS);
        return s[PW-1:0];
    endfunction

    // Window that keeps row x in the bottom line, one further down if the line wrapped.
    function automatic logic [RW-1:0] f_view(input logic [RW-1:0] x, input logic wrap);
        logic [XW-1:0] xx;
        logic [XW-1:0] v;
        xx = XW'(x);
        v  = '0;
        if (xx + XW'(1) >= VIS) v = wrap ? xx + XW'(2) - VIS : xx + XW'(1) - VIS;
        return v[RW-1:0];
    endfunction

    assign w_rowx  = XW'(r_row);
    assign w_viewx = XW'(r_view);
    assign w_stepx = XW'(i_scroll_step);
    assign w_room  = w_rowx + XW'(1) - w_viewx - VIS;
    assign w_rdrow = w_viewx + XW'(i_view_row);
    assign w_vc_ext = 9'(i_view_column);
    assign w_ub_row = (r_col == '0) ? r_row - RW'(1) : r_row;
    assign w_ub_col = (r_col == '0) ? COL_LAST : r_col - CW'(1);

    always_comb begin
        w_raddr   = {f_phys(w_rdrow[PW-1:0], r_base), w_vc_ext[CW-1:0]};
        w_rd_mode = RD_MEM;
        if (w_rdrow >= HIST) w_rd_mode = RD_BLANK;
        if (XW'(i_view_row) >= VIS || w_vc_ext >= 9'(COLUMNS)) w_rd_mode = RD_ZERO;
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt;
        w_wdata = {r_fill_attr, scb_pkg::SPACE_CODE};
        if (i_cmd.sweep) begin
            w_we = 1'b1;
        end else if (i_cmd.row_clr) begin
            w_we    = 1'b1;
            w_waddr = {r_clr_row, r_cnt[CW-1:0]};
            w_wdata = {i_text_color, scb_pkg::SPACE_CODE};
        end else if (i_cmd.put) begin
            w_we    = (r_char != scb_pkg::NEWLINE_CODE);
            w_waddr = {f_phys(r_row[PW-1:0], r_base), r_col};
            w_wdata = {i_text_color, r_char};
        end else if (i_cmd.undo_step) begin
            w_we    = 1'b1;
            w_waddr = {f_phys(w_ub_row[PW-1:0], r_base), w_ub_col};
            w_wdata = {i_text_color, scb_pkg::SPACE_CODE};
        end
    end

    always_comb begin
        n_row       = r_row;
        n_col       = r_col;
        n_view      = r_view;
        n_prev      = r_prev;
        n_base      = r_base;
        n_fill_attr = r_fill_attr;
        n_cnt       = r_cnt;
        if (i_cmd.sweep || i_cmd.row_clr) n_cnt = r_cnt + AW'(1);
        if (i_cmd.shift_begin) begin
            n_base = f_phys(PW'(1), r_base);
            n_row  = ROW_LAST;
            n_cnt  = '0;
        end
        if (i_cmd.clear_begin) begin
            n_row       = '0;
            n_col       = '0;
            n_view      = '0;
            n_base      = '0;
            n_fill_attr = i_text_color;
            n_cnt       = '0;
        end
        if (i_cmd.put) begin
            if (r_char == scb_pkg::NEWLINE_CODE || r_col == COL_LAST) begin
                n_col  = '0;
                n_row  = r_row + RW'(1);
                n_view = f_view(r_row, 1'b1);
            end else begin
                n_col  = r_col + CW'(1);
                n_view = f_view(r_row, 1'b0);
            end
        end
        if (i_cmd.undo_step) begin
            n_row  = w_ub_row;
            n_col  = w_ub_col;
            n_view = f_view(w_ub_row, w_ub_col == COL_LAST);
        end
        if (i_cmd.wheel) begin
            n_prev = i_wheel_value;
            if (i_wheel_value > r_prev && w_viewx + VIS <= w_rowx) begin
                n_view = RW'(w_viewx + ((w_stepx < w_room) ? w_stepx : w_room));
            end else if (i_wheel_value < r_prev && r_view != '0) begin
                n_view = RW'(w_viewx - ((w_stepx < w_viewx) ? w_stepx : w_viewx));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_view      <= '0;
            r_prev      <= '0;
            r_base      <= '0;
            r_fill_attr <= scb_pkg::RESET_COLOR;
            r_cnt       <= '0;
        end else begin
            r_row       <= n_row;
            r_col       <= n_col;
            r_view      <= n_view;
            r_prev      <= n_prev;
            r_base      <= n_base;
            r_fill_attr <= n_fill_attr;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= i_char_code;
            r_cell <= '0;
        end
        if (i_cmd.load) begin
            r_undo <= i_undo_count;
        end else if (i_cmd.undo_step) begin
            r_undo <= r_undo - 8'd1;
        end
        if (i_cmd.shift_begin) r_clr_row <= r_base;
        if (i_cmd.read_issue) r_rd_mode <= w_rd_mode;
        if (i_cmd.cell_load) begin
            case (r_rd_mode)
                RD_MEM:   r_cell <= r_rd_data;
                RD_BLANK: r_cell <= {i_text_color, scb_pkg::SPACE_CODE};
                default:  r_cell <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (i_cmd.read_issue) r_rd_data <= r_mem[w_raddr];
    end

    assign o_stat.row_full     = (r_row == ROW_FULL);
    assign o_stat.at_origin    = (r_row == '0) && (r_col == '0);
    assign o_stat.undo_zero    = (r_undo == 8'd0);
    assign o_stat.sweep_last   = (r_cnt == CNT_LAST);
    assign o_stat.row_clr_last = (r_cnt[CW-1:0] == COL_LAST);

    assign w_rel    = 32'(r_row) - 32'(r_view);
    assign w_col32  = 32'(r_col);
    assign w_view32 = 32'(r_view);

    assign o_cell_entry      = r_cell;
    assign o_cursor_column   = w_col32[6:0];
    assign o_cursor_view_row = w_rel[7:0];
    assign o_cursor_visible  = ($signed(w_rel) < $signed(32'(VISIBLE_ROWS)));
    assign o_window_position = w_view32[6:0];

endmodule

FILE: src/text_console_scrollback.sv
// Top level of the text console engine with scrollback store.
//
// Usage: an item is accepted at a clock edge where start is high and busy is
// low. Its fields select one of: put character, wheel event, erase characters,
// clear, or read one visible cell. Exactly one result transfer follows per item,
// marked by o_done for a single cycle; the receiver cannot stall it.
// Each result carries the cell read (zero unless reading), the cursor position
// in the view, the cursor-visible flag and the first visible store row.
// Steps from acceptance to o_done: wheel and unknown actions go straight to
// the done state, put and read pass through the put or read state, a put into
// a full store first blanks the bottom row one cell a cycle, an erase of n
// characters blanks one cell per step, and clear rewrites the store one cell
// per cycle. busy falls in the cycle after o_done.
// Store rows are addressed through a circular base pointer, so scrolling the
// history never moves stored cells.
// After reset the block runs the same one-cell-a-cycle clearing pass (busy held
// high) over all HISTORY_ROWS * 2**ceil(log2(COLUMNS)) cells. Configuration writes
// over the APB port are taken at any time and should only be made while idle.
module text_console_scrollback #(
    parameter int COLUMNS      = 80,
    parameter int VISIBLE_ROWS = 25,
    parameter int HISTORY_ROWS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_action,
    input  logic [7:0]         i_char_code,
    input  logic signed [31:0] i_wheel_value,
    input  logic [7:0]         i_undo_count,
    input  logic [4:0]         i_view_row,
    input  logic [6:0]         i_view_column,
    output logic               o_done,
    output logic [15:0]        o_cell_entry,
    output logic [6:0]         o_cursor_column,
    output logic [7:0]         o_cursor_view_row,
    output logic               o_cursor_visible,
    output logic [6:0]         o_window_position,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

`include "text_console_scrollback_assert.svh"

    logic [7:0]     r_text_color;
    logic [6:0]     r_scroll_step;
    logic           w_cfg_write;
    scb_pkg::t_cmd  w_cmd;
    scb_pkg::t_stat w_stat;

    // The register index is the word address; the low byte-lane bits are ignored.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color  <= scb_pkg::RESET_COLOR;
            r_scroll_step <= scb_pkg::RESET_STEP;
        end else if (w_cfg_write) begin
            case (paddr[2])
                scb_pkg::REG_TEXT_COLOR:  r_text_color  <= pwdata[7:0];
                scb_pkg::REG_SCROLL_STEP: r_scroll_step <= pwdata[6:0];
                default:                  r_text_color  <= r_text_color;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            scb_pkg::REG_TEXT_COLOR:  prdata = 32'(r_text_color);
            scb_pkg::REG_SCROLL_STEP: prdata = 32'(r_scroll_step);
            default:                  prdata = '0;
        endcase
    end

    // The controller sequences each item; the datapath holds the cursor, window and cell store.
    scb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    scb_dp #(
        .COLUMNS      (COLUMNS),
        .VISIBLE_ROWS (VISIBLE_ROWS),
        .HISTORY_ROWS (HISTORY_ROWS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_text_color      (r_text_color),
        .i_scroll_step     (r_scroll_step),
        .i_char_code       (i_char_code),
        .i_wheel_value     (i_wheel_value),
        .i_undo_count      (i_undo_count),
        .i_view_row        (i_view_row),
        .i_view_column     (i_view_column),
        .o_cell_entry      (o_cell_entry),
        .o_cursor_column   (o_cursor_column),
        .o_cursor_view_row (o_cursor_view_row),
        .o_cursor_visible  (o_cursor_visible),
        .o_window_position (o_window_position)
    );

    `TCS_ASSERT(a_done_while_busy, o_done |-> busy, "result transfer outside an item")
    `TCS_ASSERT(a_accept_sets_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
    `TCS_ASSERT(a_done_single, o_done |=> !o_done, "result strobe longer than one cycle")

endmodule
